// ----- hw/rtl/atan_soft_clip_distortion_unit_defines.svh -----
// Assertion macros shared by the checker of the arctangent soft-clip unit.
`ifndef ATAN_SOFT_CLIP_DISTORTION_UNIT_DEFINES_SVH
`define ATAN_SOFT_CLIP_DISTORTION_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASCD_ASSERT_NOW(label, clk, dis, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASCD_ASSERT_NEXT(label, clk, dis, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/ascd_pkg.sv -----
// Shared constants, register codes, flag types and the CORDIC angle table.
package ascd_pkg;

  localparam int Q16_ONE     = 65536;
  localparam int RND_SHIFT   = 16;
  localparam int RND_HALF    = 32768;
  localparam int ANGLE_FRAC  = 23;
  localparam int ANGLE_BITS  = 23;
  localparam int ZW          = 25;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 24;
  localparam int IN_GAIN_W   = 24;
  localparam int DRIVE_W     = 20;
  localparam int WET_W       = 17;
  localparam int OUT_GAIN_W  = 24;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_INPUT_GAIN   = 3'd0,
    REG_DRIVE_GAIN   = 3'd1,
    REG_WET_FRACTION = 3'd2,
    REG_OUTPUT_GAIN  = 3'd3,
    REG_BYPASS       = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic neg;
    logic zero;
  } cordic_flags_t;

  // Angle of stage idx, round(atan(2^-idx) * 2^24 / pi).
  function automatic logic [ANGLE_BITS-1:0] angle(input int idx);
    logic [ANGLE_BITS-1:0] a;
    unique case (idx)
      0:       a = 23'd4194304;
      1:       a = 23'd2476042;
      2:       a = 23'd1308273;
      3:       a = 23'd664100;
      4:       a = 23'd333339;
      5:       a = 23'd166832;
      6:       a = 23'd83436;
      7:       a = 23'd41721;
      8:       a = 23'd20861;
      9:       a = 23'd10430;
      10:      a = 23'd5215;
      11:      a = 23'd2608;
      12:      a = 23'd1304;
      13:      a = 23'd652;
      14:      a = 23'd326;
      15:      a = 23'd163;
      16:      a = 23'd81;
      17:      a = 23'd41;
      18:      a = 23'd20;
      19:      a = 23'd10;
      20:      a = 23'd5;
      21:      a = 23'd3;
      22:      a = 23'd1;
      23:      a = 23'd1;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// ----- hw/rtl/ascd_gain.sv -----
// Input gain and drive gain stages producing the CORDIC start vector.
module ascd_gain #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  en,
  input  logic                                  in_valid,
  input  logic signed [SAMPLE_BITS-1:0]         sample,
  input  logic [ascd_pkg::IN_GAIN_W-1:0]        input_gain,
  input  logic [ascd_pkg::DRIVE_W-1:0]          drive_gain,
  output logic                                  out_valid,
  output logic signed [SAMPLE_BITS+7:0]         x_out,
  output logic signed [SAMPLE_BITS+13:0]        mag,
  output ascd_pkg::cordic_flags_t               flags,
  output logic [SAMPLE_BITS-1:0]                raw_out
);

  localparam int XW  = SAMPLE_BITS + 8;
  localparam int TW  = SAMPLE_BITS + 12;
  localparam int CW  = SAMPLE_BITS + 14;
  localparam int P0W = SAMPLE_BITS + 25;
  localparam int P1W = XW + 21;

  logic [4:0]                 v;
  logic signed [P0W-1:0]      p0;
  logic signed [XW-1:0]       x1, x2, x3;
  logic signed [P1W-1:0]      p1;
  logic signed [TW-1:0]       t3;
  logic [SAMPLE_BITS-1:0]     raw0, raw1, raw2, raw3;
  logic signed [P0W:0]        rs0;
  logic signed [P1W:0]        rs1;

  assign rs0 = (P0W+1)'(p0) + (P0W+1)'(ascd_pkg::RND_HALF);
  assign rs1 = (P1W+1)'(p1) + (P1W+1)'(ascd_pkg::RND_HALF);

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0         <= sample * $signed({1'b0, input_gain});
      raw0       <= sample;
      x1         <= rs0[ascd_pkg::RND_SHIFT +: XW];
      raw1       <= raw0;
      p1         <= x1 * $signed({1'b0, drive_gain});
      x2         <= x1;
      raw2       <= raw1;
      t3         <= rs1[ascd_pkg::RND_SHIFT +: TW];
      x3         <= x2;
      raw3       <= raw2;
      mag        <= t3[TW-1] ? -(CW'(t3)) : CW'(t3);
      flags.neg  <= t3[TW-1];
      flags.zero <= (t3 == '0);
      x_out      <= x3;
      raw_out    <= raw3;
    end
  end

  assign out_valid = v[4];

endmodule

// ----- hw/rtl/ascd_cordic.sv -----
// Vectoring CORDIC, one register stage per iteration, with sign restore and alignment.
module ascd_cordic #(
  parameter int SAMPLE_BITS   = 24,
  parameter int CORDIC_STAGES = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  en,
  input  logic                                  in_valid,
  input  logic signed [SAMPLE_BITS+13:0]        mag,
  input  ascd_pkg::cordic_flags_t               flags,
  input  logic signed [SAMPLE_BITS+7:0]         x_in,
  input  logic [SAMPLE_BITS-1:0]                raw_in,
  output logic                                  out_valid,
  output logic signed [SAMPLE_BITS+1:0]         wet,
  output logic signed [SAMPLE_BITS+7:0]         x_out,
  output logic [SAMPLE_BITS-1:0]                raw_out
);

  localparam int CW    = SAMPLE_BITS + 14;
  localparam int XW    = SAMPLE_BITS + 8;
  localparam int WW    = SAMPLE_BITS + 2;
  localparam int ZW    = ascd_pkg::ZW;
  localparam int N     = CORDIC_STAGES;
  localparam int FRAC  = SAMPLE_BITS - 1;
  localparam logic signed [CW-1:0] X_INIT = CW'(1) << FRAC;

  logic signed [CW-1:0]        cx [1:N];
  logic signed [CW-1:0]        cy [1:N];
  logic signed [ZW-1:0]        cz [1:N];
  ascd_pkg::cordic_flags_t     cf [1:N];
  logic signed [XW-1:0]        cd [1:N];
  logic [SAMPLE_BITS-1:0]      cr [1:N];
  logic [N:1]                  cv;
  logic                        v_out;
  logic signed [ZW-1:0]        zs;
  logic signed [WW-1:0]        wet_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      cv    <= '0;
      v_out <= 1'b0;
    end else if (en) begin
      cv    <= {cv[N-1:1], in_valid};
      v_out <= cv[N];
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic signed [CW-1:0]     xi, yi;
    logic signed [ZW-1:0]     zi;
    ascd_pkg::cordic_flags_t  fi;
    logic signed [XW-1:0]     di;
    logic [SAMPLE_BITS-1:0]   ri;

    if (i == 0) begin : g_src
      assign xi = X_INIT;
      assign yi = mag;
      assign zi = '0;
      assign fi = flags;
      assign di = x_in;
      assign ri = raw_in;
    end else begin : g_src
      assign xi = cx[i];
      assign yi = cy[i];
      assign zi = cz[i];
      assign fi = cf[i];
      assign di = cd[i];
      assign ri = cr[i];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (yi >= 0) begin
          cx[i+1] <= xi + (yi >>> i);
          cy[i+1] <= yi - (xi >>> i);
          cz[i+1] <= zi + $signed(ZW'(ascd_pkg::angle(i)));
        end else begin
          cx[i+1] <= xi - (yi >>> i);
          cy[i+1] <= yi + (xi >>> i);
          cz[i+1] <= zi - $signed(ZW'(ascd_pkg::angle(i)));
        end
        cf[i+1] <= fi;
        cd[i+1] <= di;
        cr[i+1] <= ri;
      end
    end
  end

  always_comb begin
    if (cf[N].zero) begin
      zs = '0;
    end else if (cf[N].neg) begin
      zs = -cz[N];
    end else begin
      zs = cz[N];
    end
  end

  if (FRAC >= ascd_pkg::ANGLE_FRAC) begin : g_align_left
    localparam int ALIGN_L = FRAC - ascd_pkg::ANGLE_FRAC;
    assign wet_c = WW'(zs) <<< ALIGN_L;
  end else begin : g_align_right
    localparam int ALIGN_R = ascd_pkg::ANGLE_FRAC - FRAC;
    logic signed [ZW:0] rs;
    assign rs    = (ZW+1)'(zs) + ((ZW+1)'(1) <<< (ALIGN_R - 1));
    assign wet_c = WW'($signed(rs[ZW:ALIGN_R]));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wet     <= wet_c;
      x_out   <= cd[N];
      raw_out <= cr[N];
    end
  end

  assign out_valid = v_out;

endmodule

// ----- hw/rtl/ascd_blend.sv -----
// Dry/wet blend, output gain, saturation and bypass selection.
module ascd_blend #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  en,
  input  logic                                  in_valid,
  input  logic signed [SAMPLE_BITS+7:0]         x_in,
  input  logic signed [SAMPLE_BITS+1:0]         wet,
  input  logic [SAMPLE_BITS-1:0]                raw_in,
  input  logic [ascd_pkg::WET_W-1:0]            wet_fraction,
  input  logic [ascd_pkg::OUT_GAIN_W-1:0]       output_gain,
  input  logic                                  bypass,
  output logic                                  out_valid,
  output logic [SAMPLE_BITS-1:0]                sample_out,
  output logic                                  clipped
);

  localparam int WET_W = ascd_pkg::WET_W;
  localparam int XW    = SAMPLE_BITS + 8;
  localparam int WW    = SAMPLE_BITS + 2;
  localparam int PDW   = XW + WET_W + 1;
  localparam int PWW   = WW + WET_W + 1;
  localparam int SW    = SAMPLE_BITS + 27;
  localparam int MW    = SAMPLE_BITS + 10;
  localparam int PYW   = MW + ascd_pkg::OUT_GAIN_W + 1;
  localparam int YW    = SAMPLE_BITS + 19;
  localparam int HB    = YW - SAMPLE_BITS + 1;

  logic [3:0]                 v;
  logic [WET_W-1:0]           w_wet, w_dry;
  logic signed [PDW-1:0]      pd;
  logic signed [PWW-1:0]      pw;
  logic signed [SW-1:0]       sum;
  logic signed [MW-1:0]       mix;
  logic signed [PYW-1:0]      py;
  logic signed [PYW:0]        rs;
  logic signed [YW-1:0]       y;
  logic [HB-1:0]              top_bits;
  logic                       ovf;
  logic [SAMPLE_BITS-1:0]     sat;
  logic [SAMPLE_BITS-1:0]     raw0, raw1, raw2;

  assign w_wet = (wet_fraction > WET_W'(ascd_pkg::Q16_ONE)) ? WET_W'(ascd_pkg::Q16_ONE)
                                                            : wet_fraction;
  assign w_dry = WET_W'(ascd_pkg::Q16_ONE) - w_wet;

  assign sum = SW'(pd) + SW'(pw) + SW'(ascd_pkg::RND_HALF);
  assign rs  = (PYW+1)'(py) + (PYW+1)'(ascd_pkg::RND_HALF);
  assign y   = rs[ascd_pkg::RND_SHIFT +: YW];

  assign top_bits = y[YW-1:SAMPLE_BITS-1];
  assign ovf      = !((&top_bits) || !(|top_bits));
  assign sat      = y[YW-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                            : {1'b0, {(SAMPLE_BITS-1){1'b1}}};

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pd   <= x_in * $signed({1'b0, w_dry});
      pw   <= wet * $signed({1'b0, w_wet});
      raw0 <= raw_in;
      mix  <= sum[ascd_pkg::RND_SHIFT +: MW];
      raw1 <= raw0;
      py   <= mix * $signed({1'b0, output_gain});
      raw2 <= raw1;
      if (bypass) begin
        sample_out <= raw2;
        clipped    <= 1'b0;
      end else begin
        sample_out <= ovf ? sat : y[SAMPLE_BITS-1:0];
        clipped    <= ovf;
      end
    end
  end

  assign out_valid = v[3];

endmodule

// ----- hw/rtl/atan_soft_clip_distortion_unit.sv -----
// Top level of the arctangent soft-clip waveshaper: config registers, pipeline, output skid.
//
// Usage:
//   Samples enter on the s_t* channel and processed samples leave on the m_t*
//   channel, one result item for each input item, in order. An item moves on a
//   rising edge where tvalid and tready are both high.
//   Gains, blend and bypass are written through cfg_we, cfg_index and cfg_data
//   while no item is in flight; an index outside the register list is ignored.
//   Throughput is one item per clock cycle while the receiver does not stall.
//   The path from acceptance to m_tvalid runs through the gain multipliers, the
//   one-iteration-per-stage CORDIC, the blend stages and the output register.
//   When the receiver stalls, the output register holds its item and one more
//   item lands in a skid register; s_tready then falls and the whole pipeline
//   freezes in place until the output drains.
//   Reset clears all valid bits and the skid stage and loads the registers with
//   unity gains, a fully wet blend and bypass off.
module atan_soft_clip_distortion_unit #(
  parameter int SAMPLE_BITS   = 24,
  parameter int CORDIC_STAGES = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // sample_in in the lowest SAMPLE_BITS bits, zero padding above.
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_tdata,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // sample_out in the lowest SAMPLE_BITS bits, zero padding above.
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]      m_tdata,
  // clipped.
  output logic                                  m_tuser,
  input  logic                                  cfg_we,
  input  logic [ascd_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [ascd_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

  logic [ascd_pkg::IN_GAIN_W-1:0]   input_gain;
  logic [ascd_pkg::DRIVE_W-1:0]     drive_gain;
  logic [ascd_pkg::WET_W-1:0]       wet_fraction;
  logic [ascd_pkg::OUT_GAIN_W-1:0]  output_gain;
  logic                             bypass;

  logic                             en;
  logic                             g_valid, c_valid, b_valid;
  logic signed [SAMPLE_BITS+7:0]    g_x, c_x;
  logic signed [SAMPLE_BITS+13:0]   g_mag;
  ascd_pkg::cordic_flags_t          g_flags;
  logic [SAMPLE_BITS-1:0]           g_raw, c_raw;
  logic signed [SAMPLE_BITS+1:0]    c_wet;
  logic [SAMPLE_BITS-1:0]           b_sample;
  logic                             b_clip;

  logic                             out_v, sk_v;
  logic [SAMPLE_BITS-1:0]           out_sample, sk_sample;
  logic                             out_clip, sk_clip;

  always_ff @(posedge clk) begin
    if (rst) begin
      input_gain   <= ascd_pkg::IN_GAIN_W'(ascd_pkg::Q16_ONE);
      drive_gain   <= ascd_pkg::DRIVE_W'(ascd_pkg::Q16_ONE);
      wet_fraction <= ascd_pkg::WET_W'(ascd_pkg::Q16_ONE);
      output_gain  <= ascd_pkg::OUT_GAIN_W'(ascd_pkg::Q16_ONE);
      bypass       <= 1'b0;
    end else if (cfg_we) begin
      unique case (ascd_pkg::cfg_reg_t'(cfg_index))
        ascd_pkg::REG_INPUT_GAIN:   input_gain   <= cfg_data[ascd_pkg::IN_GAIN_W-1:0];
        ascd_pkg::REG_DRIVE_GAIN:   drive_gain   <= cfg_data[ascd_pkg::DRIVE_W-1:0];
        ascd_pkg::REG_WET_FRACTION: wet_fraction <= cfg_data[ascd_pkg::WET_W-1:0];
        ascd_pkg::REG_OUTPUT_GAIN:  output_gain  <= cfg_data[ascd_pkg::OUT_GAIN_W-1:0];
        ascd_pkg::REG_BYPASS:       bypass       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign en       = !sk_v;
  assign s_tready = en;

  ascd_gain #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_gain (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (s_tvalid),
    .sample     ($signed(s_tdata[SAMPLE_BITS-1:0])),
    .input_gain (input_gain),
    .drive_gain (drive_gain),
    .out_valid  (g_valid),
    .x_out      (g_x),
    .mag        (g_mag),
    .flags      (g_flags),
    .raw_out    (g_raw)
  );

  ascd_cordic #(
    .SAMPLE_BITS  (SAMPLE_BITS),
    .CORDIC_STAGES(CORDIC_STAGES)
  ) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (g_valid),
    .mag       (g_mag),
    .flags     (g_flags),
    .x_in      (g_x),
    .raw_in    (g_raw),
    .out_valid (c_valid),
    .wet       (c_wet),
    .x_out     (c_x),
    .raw_out   (c_raw)
  );

  ascd_blend #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_blend (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .in_valid     (c_valid),
    .x_in         (c_x),
    .wet          (c_wet),
    .raw_in       (c_raw),
    .wet_fraction (wet_fraction),
    .output_gain  (output_gain),
    .bypass       (bypass),
    .out_valid    (b_valid),
    .sample_out   (b_sample),
    .clipped      (b_clip)
  );

  // Output register plus one skid entry; the pipeline advances only while the skid is empty.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
      sk_v  <= 1'b0;
    end else if (out_v && !m_tready) begin
      if (en && b_valid) begin
        sk_v <= 1'b1;
      end
    end else if (sk_v) begin
      out_v <= 1'b1;
      sk_v  <= 1'b0;
    end else begin
      out_v <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_v && !m_tready) begin
      if (en && b_valid) begin
        sk_sample <= b_sample;
        sk_clip   <= b_clip;
      end
    end else if (sk_v) begin
      out_sample <= sk_sample;
      out_clip   <= sk_clip;
    end else begin
      out_sample <= b_sample;
      out_clip   <= b_clip;
    end
  end

  assign m_tvalid = out_v;
  assign m_tdata  = TDATA_W'(out_sample);
  assign m_tuser  = out_clip;

endmodule

// ----- hw/rtl/ascd_port_checker.sv -----
// Port-level checker for the arctangent soft-clip unit and its bind statement.
`include "atan_soft_clip_distortion_unit_defines.svh"

module ascd_port_checker #(
  parameter int SAMPLE_BITS = 24
) (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  s_tready,
  input logic                                  m_tvalid,
  input logic                                  m_tready,
  input logic [((SAMPLE_BITS+7)/8)*8-1:0]      m_tdata,
  input logic                                  m_tuser
);

  localparam logic [SAMPLE_BITS-1:0] FULL_POS = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] FULL_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  `ASCD_ASSERT_NEXT(a_out_valid_holds, clk, rst, m_tvalid && !m_tready, m_tvalid, "m_tvalid dropped while stalled")
  `ASCD_ASSERT_NEXT(a_out_data_holds, clk, rst, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser), "output item changed while stalled")
  `ASCD_ASSERT_NOW(a_clip_at_full_scale, clk, rst, m_tvalid && m_tuser, m_tdata[SAMPLE_BITS-1:0] == FULL_POS || m_tdata[SAMPLE_BITS-1:0] == FULL_NEG, "clipped item is not at full scale")
  `ASCD_ASSERT_NOW(a_ready_low_only_when_full, clk, rst, !s_tready, m_tvalid, "s_tready low with an empty output")
  `ASCD_ASSERT_NEXT(a_reset_empties, clk, 1'b0, rst, !m_tvalid && s_tready, "reset did not empty the output stage")

endmodule

bind atan_soft_clip_distortion_unit ascd_port_checker #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_port_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// ----- tb/atan_soft_clip_distortion_unit_test.sv -----
// Self-checking testbench for the arctangent soft-clip waveshaper with random stream stalls.
`timescale 1ns / 1ps

module atan_soft_clip_distortion_unit_test;

  localparam int SAMPLE_BITS   = 24;
  localparam int CORDIC_STAGES = 16;
  localparam int DUT_LATENCY   = CORDIC_STAGES + 10;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int PHASE_ITEMS   = 150;
  localparam int RANDOM_PHASES = 12;
  localparam int REPORT_MAX    = 10;
  localparam logic [23:0] SAMPLE_MAX = 24'h7FFFFF;
  localparam logic [23:0] SAMPLE_MIN = 24'h800000;
  localparam logic [23:0] GAIN_MAX   = 24'hFFFFFF;
  localparam logic [23:0] UNITY      = 24'd65536;

  typedef struct packed {
    logic [23:0] sample;
    logic        clipped;
  } shaped_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        m_tuser;
  logic        cfg_we = 1'b0;
  logic [ascd_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [ascd_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  logic [ascd_pkg::IN_GAIN_W-1:0]  in_gain_q  = UNITY;
  logic [ascd_pkg::DRIVE_W-1:0]    drive_q    = 20'd65536;
  logic [ascd_pkg::WET_W-1:0]      wet_q      = 17'd65536;
  logic [ascd_pkg::OUT_GAIN_W-1:0] out_gain_q = UNITY;
  logic                            bypass_q   = 1'b0;

  longint stage_angle [16] = '{
    4194304, 2476042, 1308273, 664100, 333339, 166832, 83436, 41721,
    20861, 10430, 5215, 2608, 1304, 652, 326, 163
  };

  logic [23:0] samples_to_send [$];
  shaped_t     expected_out [$];
  bit          src_idle_en = 1'b1;
  bit          sink_idle_en = 1'b1;
  int          src_gap = 0;
  int          sink_gap = 0;
  int          mismatches = 0;
  int          cycles = 0;

  atan_soft_clip_distortion_unit #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .CORDIC_STAGES(CORDIC_STAGES)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint round16(input longint v);
    return (v + longint'(ascd_pkg::RND_HALF)) >>> ascd_pkg::RND_SHIFT;
  endfunction

  function automatic shaped_t shape_sample(input logic [23:0] raw);
    shaped_t r;
    longint s, x, t, cx, cy, z, dx, dy, wet, w, mix, y;
    r.sample = raw;
    r.clipped = 1'b0;
    if (bypass_q)
      return r;
    s = longint'($signed(raw));
    x = round16(s * longint'(in_gain_q));
    t = round16(x * longint'(drive_q));
    wet = 0;
    if (t != 0) begin
      cx = longint'(1) << 23;
      cy = (t < 0) ? -t : t;
      z = 0;
      for (int i = 0; i < CORDIC_STAGES; i++) begin
        dx = cy >>> i;
        dy = cx >>> i;
        if (cy >= 0) begin
          cx += dx;
          cy -= dy;
          z += stage_angle[i];
        end else begin
          cx -= dx;
          cy += dy;
          z -= stage_angle[i];
        end
      end
      wet = (t < 0) ? -z : z;
    end
    w = (wet_q > 17'(ascd_pkg::Q16_ONE)) ? longint'(ascd_pkg::Q16_ONE) : longint'(wet_q);
    mix = round16(x * (longint'(ascd_pkg::Q16_ONE) - w) + wet * w);
    y = round16(mix * longint'(out_gain_q));
    if (y > 64'sd8388607) begin
      y = 64'sd8388607;
      r.clipped = 1'b1;
    end else if (y < -64'sd8388608) begin
      y = -64'sd8388608;
      r.clipped = 1'b1;
    end
    r.sample = y[23:0];
    return r;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready)
        expected_out = {expected_out, shape_sample(s_tdata)};
      if (!s_tvalid || s_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          s_tvalid <= 1'b0;
        end else if (samples_to_send.size() > 0) begin
          if (src_idle_en && $urandom_range(0, 5) == 0) begin
            src_gap = $urandom_range(0, 3);
            s_tvalid <= 1'b0;
          end else begin
            s_tvalid <= 1'b1;
            s_tdata <= samples_to_send.pop_front();
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    shaped_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_out.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("Unexpected item: sample_out %h clipped %b", m_tdata, m_tuser);
        end else begin
          want = expected_out.pop_front();
          if (m_tdata !== want.sample || m_tuser !== want.clipped) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
              $display("Mismatch: sample_out %h clipped %b, expected %h %b",
                       m_tdata, m_tuser, want.sample, want.clipped);
          end
        end
      end
      if (sink_gap > 0) begin
        sink_gap--;
        m_tready <= 1'b0;
      end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
        sink_gap = $urandom_range(0, 3);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic write_reg(input logic [ascd_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [23:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      ascd_pkg::REG_INPUT_GAIN:   in_gain_q = val;
      ascd_pkg::REG_DRIVE_GAIN:   drive_q = val[ascd_pkg::DRIVE_W-1:0];
      ascd_pkg::REG_WET_FRACTION: wet_q = val[ascd_pkg::WET_W-1:0];
      ascd_pkg::REG_OUTPUT_GAIN:  out_gain_q = val;
      ascd_pkg::REG_BYPASS:       bypass_q = val[0];
      default: ;
    endcase
  endtask

  task automatic set_all(input logic [23:0] ig, input logic [23:0] dg, input logic [23:0] wf,
                         input logic [23:0] og, input logic [23:0] bp);
    write_reg(ascd_pkg::REG_INPUT_GAIN, ig);
    write_reg(ascd_pkg::REG_DRIVE_GAIN, dg);
    write_reg(ascd_pkg::REG_WET_FRACTION, wf);
    write_reg(ascd_pkg::REG_OUTPUT_GAIN, og);
    write_reg(ascd_pkg::REG_BYPASS, bp);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    do
      @(negedge clk);
    while (samples_to_send.size() > 0 || s_tvalid || expected_out.size() > 0);
  endtask

  function automatic logic [23:0] rand_sample();
    logic [23:0] raw;
    raw = 24'($urandom);
    if ($urandom_range(0, 2) == 0)
      return raw;
    return 24'($signed(raw) >>> $urandom_range(0, 22));
  endfunction

  function automatic logic [23:0] rand_gain();
    case ($urandom_range(0, 6))
      0:       return 24'd0;
      1:       return GAIN_MAX;
      2, 3:    return 24'($urandom_range(0, 131072));
      4:       return 24'($urandom_range(0, 1 << 20));
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [23:0] rand_wet();
    case ($urandom_range(0, 4))
      0:       return 24'd0;
      1:       return UNITY;
      2:       return 24'($urandom_range(65537, 131071));
      default: return 24'($urandom_range(0, 65536)) | (24'($urandom_range(0, 127)) << 17);
    endcase
  endfunction

  initial begin
    logic [23:0] bp;
    logic [ascd_pkg::CFG_INDEX_W-1:0] bad_idx;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset values: unity gains, fully wet.
    samples_to_send = '{24'd0, 24'd1, 24'hFFFFFF, SAMPLE_MAX, SAMPLE_MIN,
                        24'h400000, 24'hC00000, 24'h0A5A5A};
    drain();

    set_all(GAIN_MAX, 24'hFFFFF, UNITY, GAIN_MAX, 24'd0);
    samples_to_send = '{SAMPLE_MAX, SAMPLE_MIN, 24'd1, 24'hFFFFFF};
    drain();

    // Zero drive argument, from a zero pre-gain and from a zero drive.
    set_all(24'd0, 24'd65536, UNITY, UNITY, 24'd0);
    samples_to_send = '{SAMPLE_MAX};
    drain();
    set_all(UNITY, 24'hF00000, UNITY, UNITY, 24'd0);
    samples_to_send = '{SAMPLE_MIN, 24'h123456};
    drain();

    // Dry only, then a wet fraction above one, with stray high bits on the writes.
    set_all(24'd131072, 24'hE40000, 24'hFE0000, GAIN_MAX, 24'hFFFFFE);
    samples_to_send = '{SAMPLE_MAX, 24'h000100, SAMPLE_MIN};
    drain();
    set_all(UNITY, 24'd262144, 24'h01FFFF, 24'd0, 24'd0);
    samples_to_send = '{SAMPLE_MAX, 24'h200000};
    drain();
    set_all(UNITY, 24'd262144, 24'h01FFFF, UNITY, 24'd0);
    samples_to_send = '{24'hE00000};
    drain();

    // Bypass, with writes to unused indexes that must change nothing.
    set_all(GAIN_MAX, 24'hFFFFF, 24'd0, GAIN_MAX, 24'hFFFFFF);
    for (int k = 1; k <= 3; k++)
      write_reg(ascd_pkg::CFG_INDEX_W'(ascd_pkg::REG_BYPASS) + ascd_pkg::CFG_INDEX_W'(k),
                24'($urandom));
    @(posedge clk);
    cfg_we <= 1'b0;
    samples_to_send = '{SAMPLE_MAX, SAMPLE_MIN, 24'd0, 24'h5A5A5A};
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      bp = 24'($urandom) & ~24'd1;
      if (p < RANDOM_PHASES - 1 && $urandom_range(0, 5) == 0)
        bp[0] = 1'b1;
      set_all(rand_gain(), rand_gain(), rand_wet(), rand_gain(), bp);
      if ($urandom_range(0, 2) == 0) begin
        bad_idx = ascd_pkg::CFG_INDEX_W'(ascd_pkg::REG_BYPASS)
                + ascd_pkg::CFG_INDEX_W'($urandom_range(1, 3));
        write_reg(bad_idx, 24'($urandom));
        @(posedge clk);
        cfg_we <= 1'b0;
      end
      src_idle_en = (p < RANDOM_PHASES - 1) && (p % 4 != 2);
      sink_idle_en = (p < RANDOM_PHASES - 1) && (p % 4 != 3);
      for (int n = 0; n < PHASE_ITEMS; n++)
        samples_to_send = {samples_to_send, rand_sample()};
      drain();
    end

    repeat (2 * DUT_LATENCY) @(posedge clk);
    if (mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
